/* rtl/sha256_stream_hasher_core_defines.svh */
// ----------------------------------------------------------------------------
// SHA-256 stream hasher: assertion macros
// Shared property forms for the port-level checker. Each expects clk and
// arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define SHS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/shs_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Sequencer states, initial hash values, round constants and the
// SHA-256 mixing functions.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_COPY
	} state_t;

	typedef logic [31:0] word_t;

	localparam word_t INIT_HASH [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_MARK = 8'h80;

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

`default_nettype wire

/* rtl/sha256_stream_hasher_core.sv */
// ----------------------------------------------------------------------------
// SHA-256 stream hasher core
// Byte-wide SHA-256 engine with one shared round unit and a rolling
// 16-word message schedule.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one message byte per word in s_tdata[7:0]; s_tuser says
//   the byte is present (low allows an empty message), s_tlast ends the
//   message. A word with neither byte nor last is dropped.
//   Master channel: eight digest words h0..h7, m_tlast on h7.
//   Each accepted byte is stored; every 64th byte starts a compression of
//   64 rounds plus a hash update, during which s_tready is low.
//   Sustained rate is set by the single round unit doing one round per cycle.
//   After the last word the block appends padding one byte per cycle
//   outside compressions (9 to 72 bytes, one or two compressions), copies
//   the digest into the output register and is ready again; the digest
//   drains while the next message loads. A second digest waits until the
//   first has been taken. With the output register free, h0 appears once
//   the padding bytes, each compression and the copy are through.
//   m_tvalid holds with stable data while m_tready is low.
//   Reset loads the initial hash values and clears length and position.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_core
	import shs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tuser,   // [0] has_byte
	input  wire logic        s_tlast,   // last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index
	output logic             m_tlast    // final_word
);

	state_t      state_q, state_d;
	word_t       hash_q [8];
	word_t       work_q [8];
	word_t       win_q [16];
	word_t       digest_q [8];
	logic [23:0] part_q;
	logic [63:0] bitlen_q;
	logic [5:0]  pos_q;
	logic [5:0]  round_q;
	logic        pad_q, first_q, len_ok_q, final_q;
	logic        out_valid_q;
	logic [2:0]  out_idx_q;

	logic        accept;
	logic        put_en;
	logic [7:0]  put_byte;
	logic        len_phase;
	logic        block_full;
	word_t       w_new, t1, t2;

	assign accept     = s_tvalid & s_tready;
	assign len_phase  = len_ok_q & (pos_q[5:3] == 3'b111);
	assign block_full = put_en & (pos_q == 6'd63);

	// Byte source: input stream while loading, pad generator while padding
	always_comb begin
		put_en   = 1'b0;
		put_byte = 8'h00;
		case (state_q)
			ST_LOAD: begin
				put_en   = accept & s_tuser;
				put_byte = s_tdata;
			end
			ST_PAD: begin
				put_en = 1'b1;
				if (first_q) begin
					put_byte = PAD_MARK;
				end else if (len_phase) begin
					put_byte = bitlen_q[63:56];
				end
			end
			default: begin
				put_en = 1'b0;
			end
		endcase
	end

	// Round unit and schedule extension
	always_comb begin
		w_new = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
		t1 = work_q[7] + big_sigma1(work_q[4])
			+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
			+ ROUND_K[round_q] + win_q[0];
		t2 = big_sigma0(work_q[0])
			+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (accept) begin
					if (block_full) begin
						state_d = ST_ROUND;
					end else if (s_tlast) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (block_full) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (round_q == 6'd63) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (final_q) begin
					state_d = ST_COPY;
				end else if (pad_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_COPY: begin
				if (!out_valid_q) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	assign s_tready = (state_q == ST_LOAD);

	// Hold state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Control, length, position and chaining hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= INIT_HASH;
			bitlen_q    <= '0;
			pos_q       <= '0;
			round_q     <= '0;
			pad_q       <= 1'b0;
			first_q     <= 1'b0;
			len_ok_q    <= 1'b0;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
		end else begin
			if (put_en) begin
				pos_q <= pos_q + 6'd1;
			end
			// count message bits; shift the length out during padding
			if (state_q == ST_LOAD && accept && s_tuser) begin
				bitlen_q <= bitlen_q + 64'd8;
			end else if (state_q == ST_PAD && !first_q && len_phase) begin
				bitlen_q <= {bitlen_q[55:0], 8'h00};
			end
			if (state_q == ST_LOAD && accept && s_tlast) begin
				pad_q   <= 1'b1;
				first_q <= 1'b1;
			end
			if (state_q == ST_PAD) begin
				if (first_q) begin
					first_q  <= 1'b0;
					len_ok_q <= (pos_q[5:3] != 3'b111);
				end else if (len_phase && pos_q == 6'd63) begin
					final_q <= 1'b1;
				end
			end
			if (state_q == ST_ROUND) begin
				round_q <= round_q + 6'd1;
			end
			if (state_q == ST_ADD) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + work_q[i];
				end
				if (pad_q && !final_q) begin
					len_ok_q <= 1'b1;
				end
			end
			// hand the digest to the output register and restart
			if (state_q == ST_COPY && !out_valid_q) begin
				hash_q      <= INIT_HASH;
				pad_q       <= 1'b0;
				len_ok_q    <= 1'b0;
				final_q     <= 1'b0;
				out_valid_q <= 1'b1;
				out_idx_q   <= '0;
			end else if (out_valid_q && m_tready) begin
				out_idx_q <= out_idx_q + 3'd1;
				if (out_idx_q == 3'd7) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	// Schedule window, word assembly, working variables and digest words
	always_ff @(posedge clk) begin
		if (put_en) begin
			part_q <= {part_q[15:0], put_byte};
			if (pos_q[1:0] == 2'b11) begin
				for (int i = 0; i < 15; i++) begin
					win_q[i] <= win_q[i + 1];
				end
				win_q[15] <= {part_q, put_byte};
			end
		end
		if (block_full) begin
			work_q <= hash_q;
		end
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w_new;
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
		if (state_q == ST_COPY && !out_valid_q) begin
			digest_q <= hash_q;
		end else if (out_valid_q && m_tready) begin
			for (int i = 0; i < 7; i++) begin
				digest_q[i] <= digest_q[i + 1];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, out_idx_q, digest_q[0]};
	assign m_tlast  = (out_idx_q == 3'd7);

endmodule

`default_nettype wire

/* rtl/shs_checker.sv */
// ----------------------------------------------------------------------------
// SHA-256 stream hasher port checker
// Watches both channels of the core: busy after the last word of a
// message, stall behaviour and the order of the eight digest words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha256_stream_hasher_core_defines.svh"

module shs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic        m_tlast
);

	logic last_in, out_word;

	assign last_in  = s_tvalid & s_tready & s_tlast;
	assign out_word = m_tvalid & m_tready;

	// a stalled digest word holds
	`SHS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled digest word changed")

	// the last word is word seven
	`SHS_ASSERT_NOW(a_last_idx, m_tvalid, m_tlast == (m_tdata[34:32] == 3'd7), "m_tlast not on word seven")

	// digest words follow each other in order
	`SHS_ASSERT_NEXT(a_idx_step, out_word && !m_tlast, m_tvalid && (m_tdata[34:32] == ($past(m_tdata[34:32]) + 3'd1)), "digest word index skipped")

	// a new digest never starts right after the last word
	`SHS_ASSERT_NEXT(a_gap_after, out_word && m_tlast, !m_tvalid, "digest restarted without a gap")

	// the core goes busy once it has taken the last word of a message
	`SHS_ASSERT_NEXT(a_busy_after_last, last_in, !s_tready, "s_tready high after the last word")

endmodule

bind sha256_stream_hasher_core shs_checker u_shs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/sv/sha256_stream_hasher_core_tb.sv */
// ----------------------------------------------------------------------------
// SHA-256 stream hasher core testbench
// Feeds messages one byte per word through the slave channel and checks each
// digest word on the master channel against a SHA-256 computed inside the
// bench. Starts with short hand-picked messages, then random messages whose
// lengths cluster around the one- and two-block padding boundaries. Both
// channels idle at random in two of three phases; in the third neither idles.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core_tb;
	import shs_pkg::*;

	localparam int RAND_WORDS = 340;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 300;

	// idling phases of the random part
	localparam logic [1:0] PH_RX_HEAVY = 2'd0;
	localparam logic [1:0] PH_TX_HEAVY = 2'd1;
	localparam logic [1:0] PH_FREE = 2'd2;

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       last;
		logic [1:0] phase;
		logic       hold;   // wait for all digests before sending
	} msg_word_t;

	typedef struct packed {
		logic [31:0] digest;
		logic [2:0]  index;
		logic        final_word;
	} digest_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	msg_word_t    word_q [$];
	digest_word_t digest_q [$];
	msg_word_t    cur_word;
	digest_word_t want_word;

	// bench copy of the hash state
	logic [31:0] hash_st [8];
	logic [31:0] blk_words [16];
	logic [63:0] len_bits;
	logic [5:0]  blk_pos;

	int rx_stall_pct = 53;
	int err_cnt = 0;
	int cyc_cnt = 0;
	int msgs_done = 0;
	int bytes_fed = 0;
	int words_checked = 0;

	sha256_stream_hasher_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// 20-unit clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

	function automatic int idle_pct(input logic [1:0] ph, input logic sender);
		case (ph)
			PH_RX_HEAVY: idle_pct = sender ? 21 : 53;
			PH_TX_HEAVY: idle_pct = sender ? 53 : 21;
			default:     idle_pct = 0;
		endcase
	endfunction

	task automatic hash_restart();
		int i;
		for (i = 0; i < 8; i++)
			hash_st[i] = SHA_IV[i];
		len_bits = '0;
		blk_pos = '0;
	endtask

	// one full 64-round compression of the current block
	task automatic sha_compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		int t;
		for (t = 0; t < 16; t++)
			w[t] = blk_words[t];
		for (t = 16; t < 64; t++)
			w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
				+ (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
		for (t = 0; t < 8; t++)
			v[t] = hash_st[t];
		for (t = 0; t < 64; t++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (t = 0; t < 8; t++)
			hash_st[t] = hash_st[t] + v[t];
	endtask

	// place a byte big-endian in the block; compress once it is full
	task automatic sha_put_byte(input logic [7:0] b);
		blk_words[blk_pos[5:2]][8 * (3 - blk_pos[1:0]) +: 8] = b;
		blk_pos = blk_pos + 6'd1;
		if (blk_pos == 6'd0)
			sha_compress();
	endtask

	// pad, append the length and queue the eight digest words
	task automatic sha_close_message();
		logic [63:0] len;
		int i;
		len = len_bits;
		sha_put_byte(8'h80);
		while (blk_pos != 6'd56)
			sha_put_byte(8'h00);
		for (i = 0; i < 8; i++)
			sha_put_byte(len[56 - 8 * i +: 8]);
		for (i = 0; i < 8; i++)
			digest_q.push_back('{digest: hash_st[i], index: 3'(i), final_word: (i == 7)});
		msgs_done++;
		hash_restart();
	endtask

	task automatic sha_take_word(input msg_word_t w);
		if (w.has_byte) begin
			sha_put_byte(w.data);
			len_bits = len_bits + 64'd8;
			bytes_fed++;
		end
		if (w.last)
			sha_close_message();
	endtask

	task automatic queue_word(input logic [7:0] d, input logic has, input logic last,
		input logic [1:0] ph, input logic hold);
		word_q.push_back('{data: d, has_byte: has, last: last, phase: ph, hold: hold});
	endtask

	// driver: predict on acceptance, then offer the next word or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			s_tlast <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				sha_take_word(cur_word);
			if (word_q.size() != 0 && !(word_q[0].hold && digest_q.size() != 0)
				&& $urandom_range(99) >= idle_pct(word_q[0].phase, 1'b1)) begin
				cur_word = word_q.pop_front();
				rx_stall_pct = idle_pct(cur_word.phase, 1'b0);
				s_tvalid <= 1'b1;
				s_tdata <= cur_word.data;
				s_tuser <= cur_word.has_byte;
				s_tlast <= cur_word.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: check each digest word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (digest_q.size() == 0) begin
					$error("digest word %08h with no prediction waiting", m_tdata[31:0]);
					err_cnt++;
				end else begin
					want_word = digest_q.pop_front();
					words_checked++;
					if (m_tdata[31:0] !== want_word.digest) begin
						$error("digest_word: expected %08h, actual %08h",
							want_word.digest, m_tdata[31:0]);
						err_cnt++;
					end
					if (m_tdata[34:32] !== want_word.index) begin
						$error("word_index: expected %0d, actual %0d",
							want_word.index, m_tdata[34:32]);
						err_cnt++;
					end
					if (m_tlast !== want_word.final_word) begin
						$error("final_word: expected %0b, actual %0b",
							want_word.final_word, m_tlast);
						err_cnt++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc_cnt++;
		if (cyc_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cyc_cnt);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int n, k, rand_words, ph, prev_ph;
		logic end_on_byte, hold;
		hash_restart();

		// hand-picked messages: idle word, empty messages, single bytes,
		// an idle word inside a message, last without a byte
		queue_word(8'hA5, 1'b0, 1'b0, PH_RX_HEAVY, 1'b0);
		queue_word(8'h3C, 1'b0, 1'b1, PH_RX_HEAVY, 1'b0);
		queue_word(8'hFF, 1'b0, 1'b1, PH_RX_HEAVY, 1'b0);
		queue_word(8'h00, 1'b1, 1'b1, PH_RX_HEAVY, 1'b0);
		queue_word(8'hFF, 1'b1, 1'b1, PH_RX_HEAVY, 1'b0);
		queue_word(8'h61, 1'b1, 1'b0, PH_RX_HEAVY, 1'b0);
		queue_word(8'hFF, 1'b0, 1'b0, PH_RX_HEAVY, 1'b0);
		queue_word(8'h62, 1'b1, 1'b0, PH_RX_HEAVY, 1'b0);
		queue_word(8'h63, 1'b1, 1'b1, PH_RX_HEAVY, 1'b0);
		queue_word(8'h5A, 1'b1, 1'b0, PH_RX_HEAVY, 1'b0);
		queue_word(8'h00, 1'b1, 1'b0, PH_RX_HEAVY, 1'b0);
		queue_word(8'hFF, 1'b1, 1'b0, PH_RX_HEAVY, 1'b0);
		queue_word(8'hC3, 1'b0, 1'b1, PH_RX_HEAVY, 1'b0);
		queue_word(8'h80, 1'b1, 1'b0, PH_RX_HEAVY, 1'b0);
		queue_word(8'h7F, 1'b1, 1'b0, PH_RX_HEAVY, 1'b0);
		queue_word(8'h01, 1'b1, 1'b1, PH_RX_HEAVY, 1'b0);

		// random messages; lengths gather around the padding boundaries
		rand_words = 0;
		prev_ph = -1;
		while (rand_words < RAND_WORDS) begin
			ph = rand_words * 3 / RAND_WORDS;
			hold = (ph != prev_ph);
			prev_ph = ph;
			case ($urandom_range(9))
				0, 1, 2, 3: n = $urandom_range(12);
				4, 5:       n = $urandom_range(70, 50);
				6:          n = $urandom_range(130, 110);
				7:          n = 0;
				default:    n = $urandom_range(40, 1);
			endcase
			end_on_byte = (n != 0) && ($urandom_range(1) == 1);
			for (k = 0; k < n; k++) begin
				if ($urandom_range(19) == 0) begin
					queue_word(8'($urandom_range(255)), 1'b0, 1'b0, 2'(ph), hold);
					hold = 1'b0;
					rand_words++;
				end
				queue_word(8'($urandom_range(255)), 1'b1, end_on_byte && (k == n - 1),
					2'(ph), hold);
				hold = 1'b0;
				rand_words++;
			end
			if (!end_on_byte) begin
				queue_word(8'($urandom_range(255)), 1'b0, 1'b1, 2'(ph), hold);
				rand_words++;
			end
		end

		// hold reset, then release it
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all words sent, all digests back, then watch for strays
		while (word_q.size() != 0 || s_tvalid || digest_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("hashed %0d messages of %0d bytes in total, %0d digest words compared",
			msgs_done, bytes_fed, words_checked);
		$display("covered empty and single-byte messages, padding into one and two blocks");
		if (err_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* sha256_stream_hasher_core.f */
+incdir+rtl
rtl/shs_pkg.sv
rtl/sha256_stream_hasher_core.sv
rtl/shs_checker.sv
tb/sv/sha256_stream_hasher_core_tb.sv
